>>> hw/rtl/node_on_primitive_selector_unit_defines.svh
// assertion helpers shared by the rtl
`ifndef NODE_ON_PRIMITIVE_SELECTOR_UNIT_DEFINES_SVH
`define NODE_ON_PRIMITIVE_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NOPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NOPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/nops_pkg.sv
package nops_pkg;

    localparam int TAG_W     = 32;
    localparam int COORD_W   = 32;
    localparam int DIM_W     = 2;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W    = 3;
    localparam int CNT_W     = 3;
    localparam int NUM_COEF  = 6;

    localparam int LINE_TOL_LSB = 1;
    localparam int POLY_TOL_LSB = 0;
    localparam int FRAC_BITS    = 16;

    // wide accumulator for the exact cross products and plane sum
    localparam int WIDE_W = 68;
    localparam int PROD_W = 2 * COORD_W;

    // horner steps after the leading coefficient: one multiply and one add stage each
    localparam int POLY_STEPS = NUM_COEF - 1;
    localparam int NUM_STG    = 2 * POLY_STEPS + 1;

    localparam logic [MODE_W-1:0] MODE_SEG    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PLANE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POLY_X = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POLY_Y = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POLY_Z = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd2;

    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [PROD_W-1:0]  p;
        logic                      is_poly;
        logic                      lp_hit;
    } pipe_t;

endpackage

>>> hw/rtl/node_on_primitive_selector_unit.sv
// channel   | direction | handshake          | payload
// request   | in        | in_valid/in_ready  | node_tag, dim_count, coord_x/y/z
// result    | out       | out_valid/out_ready| selected_tag
// config    | in        | cfg_we             | cfg_idx, cfg_wdata
//
// one node per cycle while out_ready does not hold the pipeline; a request reaches the output
// register through stage 0 and the five multiply/add pairs of the horner chain
// rst_n clears all valid bits and the config registers (coef_count to 1)
// the whole pipeline holds while a result waits and out_ready is low
// nodes that miss the primitive leave no result
`include "node_on_primitive_selector_unit_defines.svh"

module node_on_primitive_selector_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [nops_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [nops_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [nops_pkg::TAG_W-1:0]             node_tag,
    input  logic [nops_pkg::DIM_W-1:0]             dim_count,
    input  logic signed [nops_pkg::COORD_W-1:0]    coord_x,
    input  logic signed [nops_pkg::COORD_W-1:0]    coord_y,
    input  logic signed [nops_pkg::COORD_W-1:0]    coord_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [nops_pkg::TAG_W-1:0]             selected_tag
);

    localparam int CW = nops_pkg::COORD_W;
    localparam int DW = CW + 1;
    localparam int QW = 2 * DW;
    localparam int WW = nops_pkg::WIDE_W;
    localparam int PW = nops_pkg::PROD_W;
    localparam int NS = nops_pkg::NUM_STG;

    function automatic logic in_unit(input logic signed [DW-1:0] n,
                                     input logic signed [DW-1:0] d);
        logic r;
        if (d > 0)
            r = (n >= 0) && (n <= d);
        else
            r = (n <= 0) && (n >= d);
        return r;
    endfunction

    function automatic logic in_tol(input logic signed [WW-1:0] v,
                                    input logic signed [WW-1:0] tol);
        return (v <= tol) && (v >= -tol);
    endfunction

    // configuration
    logic [nops_pkg::MODE_W-1:0]   mode_reg;
    logic [nops_pkg::CNT_W-1:0]    coef_count_reg;
    logic signed [CW-1:0]          coef_reg [nops_pkg::NUM_COEF];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= nops_pkg::MODE_SEG;
            coef_count_reg <= 3'd1;
            for (int i = 0; i < nops_pkg::NUM_COEF; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                nops_pkg::REG_MODE:  mode_reg       <= cfg_wdata[nops_pkg::MODE_W-1:0];
                nops_pkg::REG_COUNT: coef_count_reg <= cfg_wdata[nops_pkg::CNT_W-1:0];
                default:             coef_reg[3'(cfg_idx - nops_pkg::REG_COEF0)] <= cfg_wdata;
            endcase
        end
    end

    // pipeline advance
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 0: differences, counts, plane products
    logic signed [CW-1:0] m [3];
    logic signed [DW-1:0] t_c [3];
    logic signed [DW-1:0] d_c [3];
    logic signed [PW-1:0] pp_c [3];
    logic [1:0]           cnt3;
    logic [1:0]           n_c;
    logic [1:0]           axis;
    logic                 poly_mode;
    nops_pkg::pipe_t      p0_c;

    always_comb
    begin
        m[0] = coord_x;
        m[1] = coord_y;
        m[2] = coord_z;
        cnt3 = (coef_count_reg > 3'd3) ? 2'd3 : coef_count_reg[1:0];
        n_c  = (dim_count < cnt3) ? dim_count : cnt3;
        for (int k = 0; k < 3; k++)
        begin
            t_c[k] = DW'(m[k]) - DW'(coef_reg[k]);
            d_c[k] = DW'(coef_reg[k+3]) - DW'(coef_reg[k]);
            pp_c[k] = '0;
            if (2'(k) < n_c)
                pp_c[k] = coef_reg[k] * m[k];
        end
        poly_mode = mode_reg inside {nops_pkg::MODE_POLY_X, nops_pkg::MODE_POLY_Y,
                                     nops_pkg::MODE_POLY_Z};
        axis = 2'(mode_reg - nops_pkg::MODE_POLY_X);
        p0_c.tag     = node_tag;
        p0_c.is_poly = poly_mode && (dim_count > axis);
        case (axis)
            2'd0:    p0_c.x = coord_x;
            2'd1:    p0_c.x = coord_y;
            default: p0_c.x = coord_z;
        endcase
        p0_c.y      = (coef_count_reg != '0) ? coef_reg[0] : '0;
        p0_c.p      = '0;
        p0_c.lp_hit = 1'b0;
    end

    logic signed [DW-1:0] t_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic signed [PW-1:0] pp_reg [3];
    logic [1:0]           n0_reg;
    logic                 seg0_reg;
    logic                 plane0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg      <= t_c;
            d_reg      <= d_c;
            pp_reg     <= pp_c;
            n0_reg     <= n_c;
            seg0_reg   <= (mode_reg == nops_pkg::MODE_SEG) && (n_c != '0);
            plane0_reg <= (mode_reg == nops_pkg::MODE_PLANE) && (n_c != '0);
        end
    end

    // stage 1: cross products, unit tests, plane sum
    logic signed [QW-1:0] q1a_reg, q1b_reg, q2a_reg, q2b_reg;
    logic signed [WW-1:0] sum_reg;
    logic signed [WW-1:0] tol_reg;
    logic                 u0_reg, d0z_reg, t0z_reg, ok1_reg, ok2_reg;
    logic [1:0]           n1_reg;
    logic                 seg1_reg, plane1_reg;
    logic [DW:0]          d0_mag;
    logic signed [WW-1:0] sum_next;

    always_comb
    begin
        d0_mag   = d_reg[0][DW-1] ? -(DW+1)'(d_reg[0]) : (DW+1)'(d_reg[0]);
        sum_next = WW'(pp_reg[0]) + WW'(pp_reg[1]) + WW'(pp_reg[2])
                 + (WW'(coef_reg[3]) <<< nops_pkg::FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1a_reg    <= t_reg[0] * d_reg[1];
            q1b_reg    <= t_reg[1] * d_reg[0];
            q2a_reg    <= t_reg[0] * d_reg[2];
            q2b_reg    <= t_reg[2] * d_reg[0];
            tol_reg    <= WW'(d0_mag) * WW'(nops_pkg::LINE_TOL_LSB);
            sum_reg    <= sum_next;
            u0_reg     <= in_unit(t_reg[0], d_reg[0]);
            d0z_reg    <= (d_reg[0] == '0);
            t0z_reg    <= (t_reg[0] == '0);
            ok1_reg    <= (d_reg[1] == '0) ? (t_reg[1] == '0) : in_unit(t_reg[1], d_reg[1]);
            ok2_reg    <= (d_reg[2] == '0) ? (t_reg[2] == '0) : in_unit(t_reg[2], d_reg[2]);
            n1_reg     <= n0_reg;
            seg1_reg   <= seg0_reg;
            plane1_reg <= plane0_reg;
        end
    end

    // stage 2: tolerance checks of segment and plane
    logic signed [WW-1:0] dev1, dev2;
    logic                 w1, w2, seg_hit, plane_hit, lp_hit_c;

    always_comb
    begin
        dev1 = WW'(q1a_reg) - WW'(q1b_reg);
        dev2 = WW'(q2a_reg) - WW'(q2b_reg);
        w1   = in_tol(dev1, tol_reg);
        w2   = in_tol(dev2, tol_reg);
        if (d0z_reg)
            seg_hit = t0z_reg && ((n1_reg < 2'd2) || ok1_reg) && ((n1_reg < 2'd3) || ok2_reg);
        else
            seg_hit = u0_reg && ((n1_reg < 2'd2) || w1) && ((n1_reg < 2'd3) || w2);
        plane_hit = in_tol(sum_reg, WW'(nops_pkg::LINE_TOL_LSB) <<< nops_pkg::FRAC_BITS);
        lp_hit_c  = (seg1_reg && seg_hit) || (plane1_reg && plane_hit);
    end

    // horner chain: odd stages multiply, even stages floor, add and saturate for coefficients below coef_count
    nops_pkg::pipe_t pipe_reg  [NS];
    nops_pkg::pipe_t pipe_next [NS];
    logic            vld_reg   [NS];
    logic signed [PW-1:0] hsum [NS];

    always_comb
    begin
        pipe_next[0] = p0_c;
        hsum[0]      = '0;
        for (int s = 1; s < NS; s++)
        begin
            pipe_next[s] = pipe_reg[s-1];
            hsum[s] = (pipe_reg[s-1].p >>> nops_pkg::FRAC_BITS) + PW'(coef_reg[s/2]);
            if (s % 2 == 1)
                pipe_next[s].p = pipe_reg[s-1].y * pipe_reg[s-1].x;
            else if (3'(s/2) < coef_count_reg)
            begin
                if (hsum[s] > PW'(32'sh7FFF_FFFF))
                    pipe_next[s].y = 32'sh7FFF_FFFF;
                else if (hsum[s] < -PW'(33'sh0_8000_0000))
                    pipe_next[s].y = 32'sh8000_0000;
                else
                    pipe_next[s].y = hsum[s][CW-1:0];
            end
            if (s == 2)
                pipe_next[s].lp_hit = lp_hit_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pipe_reg <= pipe_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // output register
    logic                         poly_hit;
    logic [nops_pkg::TAG_W-1:0]   selected_tag_reg;

    assign poly_hit = pipe_reg[NS-1].is_poly
                   && (pipe_reg[NS-1].y <= CW'(nops_pkg::POLY_TOL_LSB))
                   && (pipe_reg[NS-1].y >= -CW'(nops_pkg::POLY_TOL_LSB));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[NS-1] && (pipe_reg[NS-1].lp_hit || poly_hit);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            selected_tag_reg <= pipe_reg[NS-1].tag;
    end

    assign out_valid    = out_valid_reg;
    assign selected_tag = selected_tag_reg;

    `NOPS_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_reg[0], "accepted request lost")
    `NOPS_ASSERT_NEXT(a_stall_holds, !adv && vld_reg[NS-1], vld_reg[NS-1], "stalled stage dropped")
    `NOPS_ASSERT_NOW(a_result_source, $rose(out_valid), $past(vld_reg[NS-1]), "result from nowhere")

endmodule

>>> dv/node_on_primitive_selector_checker.sv
`timescale 1ns / 1ps

module node_on_primitive_selector_checker
    import nops_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_idx,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [TAG_W-1:0]           node_tag,
    input  logic [DIM_W-1:0]           dim_count,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic signed [COORD_W-1:0]  coord_z,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [TAG_W-1:0]           selected_tag,
    output int                         error_count,
    output int                         tags_pending
);

    logic [MODE_W-1:0]          sel_mode;
    logic [CNT_W-1:0]           sel_count;
    logic signed [COORD_W-1:0]  sel_coef [NUM_COEF];
    logic [TAG_W-1:0]           tag_queue [$];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_mode  <= MODE_SEG;
            sel_count <= 3'd1;
            for (int i = 0; i < NUM_COEF; i++)
                sel_coef[i] <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_MODE)
                sel_mode <= cfg_wdata[MODE_W-1:0];
            else if (cfg_idx == REG_COUNT)
                sel_count <= cfg_wdata[CNT_W-1:0];
            else
                sel_coef[cfg_idx - REG_COEF0] <= cfg_wdata;
        end
    end

    function automatic bit in_span(longint n, longint d);
        if (d > 0)
            return n >= 0 && n <= d;
        return n <= 0 && n >= d;
    endfunction

    function automatic bit on_segment(longint pt[3], int n);
        longint d0, t0, dk, tk;
        logic signed [127:0] acc, tol;
        logic signed [127:0] a, b, c, d;
        d0 = longint'(sel_coef[3]) - longint'(sel_coef[0]);
        t0 = pt[0] - longint'(sel_coef[0]);
        if (d0 != 0)
        begin
            if (!in_span(t0, d0))
                return 0;
            tol = d0 < 0 ? -d0 : d0;
            tol = tol * LINE_TOL_LSB;
            for (int k = 1; k < n; k++)
            begin
                dk = longint'(sel_coef[3+k]) - longint'(sel_coef[k]);
                tk = pt[k] - longint'(sel_coef[k]);
                a = t0;
                b = dk;
                c = tk;
                d = d0;
                acc = a * b - c * d;
                if (acc > tol || acc < -tol)
                    return 0;
            end
            return 1;
        end
        if (t0 != 0)
            return 0;
        for (int k = 1; k < n; k++)
        begin
            dk = longint'(sel_coef[3+k]) - longint'(sel_coef[k]);
            tk = pt[k] - longint'(sel_coef[k]);
            if (dk == 0)
            begin
                if (tk != 0)
                    return 0;
            end
            else if (!in_span(tk, dk))
                return 0;
        end
        return 1;
    endfunction

    function automatic bit on_plane(longint pt[3], int n);
        logic signed [127:0] acc, a, b, tol;
        acc = 0;
        for (int k = 0; k < n; k++)
        begin
            a = longint'(sel_coef[k]);
            b = pt[k];
            acc = acc + a * b;
        end
        a = longint'(sel_coef[3]);
        acc = acc + (a <<< FRAC_BITS);
        tol = LINE_TOL_LSB;
        tol = tol <<< FRAC_BITS;
        return acc <= tol && acc >= -tol;
    endfunction

    function automatic bit on_root(longint x, int steps);
        longint y;
        y = 0;
        for (int i = 0; i < steps; i++)
        begin
            y = ((y * x) >>> FRAC_BITS) + longint'(sel_coef[i]);
            if (y > 64'sd2147483647)
                y = 64'sd2147483647;
            if (y < -64'sd2147483648)
                y = -64'sd2147483648;
        end
        return (y < 0 ? -y : y) <= POLY_TOL_LSB;
    endfunction

    function automatic bit node_selected(int dims, longint pt[3]);
        int n, axis;
        n = sel_count > 3 ? 3 : int'(sel_count);
        if (dims < n)
            n = dims;
        if (sel_mode == MODE_SEG)
            return n > 0 && on_segment(pt, n);
        if (sel_mode == MODE_PLANE)
            return n > 0 && on_plane(pt, n);
        if (sel_mode == MODE_POLY_X || sel_mode == MODE_POLY_Y || sel_mode == MODE_POLY_Z)
        begin
            axis = int'(sel_mode - MODE_POLY_X);
            if (dims > axis)
                return on_root(pt[axis], sel_count > NUM_COEF ? NUM_COEF : int'(sel_count));
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        longint pt[3];
        logic [TAG_W-1:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pt[0] = longint'(coord_x);
                pt[1] = longint'(coord_y);
                pt[2] = longint'(coord_z);
                if (node_selected(int'(dim_count), pt))
                    tag_queue.push_back(node_tag);
            end
            if (out_valid && out_ready)
            begin
                if (tag_queue.size() == 0)
                begin
                    $error("selected_tag: expected none, actual %h", selected_tag);
                    error_count++;
                end
                else
                begin
                    want = tag_queue.pop_front();
                    if (want !== selected_tag)
                    begin
                        $error("selected_tag: expected %h, actual %h", want, selected_tag);
                        error_count++;
                    end
                end
            end
        end
        tags_pending = tag_queue.size();
    end

    initial
    begin
        error_count  = 0;
        tags_pending = 0;
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import nops_pkg::*;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 9;
    localparam int STALL_LIMIT     = 4000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_idx;
    logic [CFG_W-1:0]          cfg_wdata;
    logic                      in_valid;
    logic                      in_ready;
    logic [TAG_W-1:0]          node_tag;
    logic [DIM_W-1:0]          dim_count;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      out_valid;
    logic                      out_ready;
    logic [TAG_W-1:0]          selected_tag;

    int error_count;
    int tags_pending;
    int nodes_sent;
    int tx_idle;
    int rx_idle;
    int quiet_cycles;
    bit draining;

    // configuration currently loaded, used to shape the requests
    logic [MODE_W-1:0]         cur_mode;
    int                        cur_count;
    longint                    cur_coef [NUM_COEF];
    longint                    seg_step [3];
    longint                    root_a, root_b;

    node_on_primitive_selector_unit i_dut (.*);

    node_on_primitive_selector_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side
    always @(posedge clk)
        out_ready <= draining || ($urandom_range(99) >= rx_idle);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic longint srand(int bits);
        return longint'($urandom_range(0, (1 << (bits + 1)) - 1)) - (longint'(1) << bits);
    endfunction

    task automatic send_node(logic [TAG_W-1:0] tag, int dims, longint x, longint y, longint z);
        int third;
        third = (NUM_PHASES * ITEMS_PER_PHASE) / 3;
        tx_idle = nodes_sent < third ? 31 : (nodes_sent < 2 * third ? 82 : 0);
        rx_idle = nodes_sent < third ? 82 : (nodes_sent < 2 * third ? 31 : 0);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        node_tag  <= tag;
        dim_count <= DIM_W'(dims);
        coord_x   <= COORD_W'(x);
        coord_y   <= COORD_W'(y);
        coord_z   <= COORD_W'(z);
        do
            @(posedge clk);
        while (!in_ready);
        nodes_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        draining <= 1'b1;
        @(posedge clk);
        while (tags_pending != 0)
            @(posedge clk);
        // misses leave no result but may still be in flight
        repeat (20) @(posedge clk);
        draining <= 1'b0;
    endtask

    task automatic load_primitive(logic [MODE_W-1:0] mode, int count, longint c[NUM_COEF]);
        cur_mode  = mode;
        cur_count = count;
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_MODE;
        cfg_wdata <= CFG_W'(mode);
        @(posedge clk);
        cfg_idx   <= REG_COUNT;
        cfg_wdata <= CFG_W'(count);
        @(posedge clk);
        for (int i = 0; i < NUM_COEF; i++)
        begin
            cur_coef[i] = longint'(signed'(CFG_W'(c[i])));
            cfg_idx   <= REG_COEF0 + CFG_IDX_W'(i);
            cfg_wdata <= CFG_W'(c[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // segment from a random start with steps that divide it into 16 parts
    task automatic pick_segment(bit flat_x, int count);
        longint c[NUM_COEF];
        for (int k = 0; k < 3; k++)
        begin
            c[k] = srand(20);
            seg_step[k] = (flat_x && k == 0) ? 0 : srand(11);
            c[3+k] = c[k] + 16 * seg_step[k];
        end
        load_primitive(MODE_SEG, count, c);
    endtask

    task automatic pick_plane(int count, bit extreme);
        longint c[NUM_COEF];
        c[0] = 65536;
        c[1] = srand(18);
        c[2] = srand(18);
        c[3] = srand(20);
        c[4] = srand(31);
        c[5] = srand(31);
        if (extreme)
        begin
            c[0] = -64'sd2147483648;
            c[3] = 64'sd2147483647;
        end
        load_primitive(MODE_PLANE, count, c);
    endtask

    // quadratic with two integer roots
    task automatic pick_roots(logic [MODE_W-1:0] mode, int count);
        longint c[NUM_COEF];
        root_a = srand(3) <<< FRAC_BITS;
        root_b = srand(3) <<< FRAC_BITS;
        c[0] = 65536;
        c[1] = -(root_a + root_b);
        c[2] = (root_a * root_b) >>> FRAC_BITS;
        c[3] = srand(31);
        c[4] = srand(31);
        c[5] = srand(31);
        load_primitive(mode, count, c);
    endtask

    task automatic random_node();
        longint p[3];
        longint rest;
        int dims, j, n;
        dims = $urandom_range(3);
        for (int k = 0; k < 3; k++)
            p[k] = srand(31);
        if ($urandom_range(99) < 75)
        begin
            if (dims == 0 && $urandom_range(3) != 0)
                dims = 3;
            if (cur_mode == MODE_SEG)
            begin
                j = $urandom_range(0, 18) - 1;
                for (int k = 0; k < 3; k++)
                    p[k] = cur_coef[k] + j * seg_step[k];
                if ($urandom_range(3) == 0)
                    p[$urandom_range(2)] += $urandom_range(0, 4) - 2;
            end
            else if (cur_mode == MODE_PLANE)
            begin
                n = cur_count > 3 ? 3 : cur_count;
                if (dims < n)
                    n = dims;
                p[1] = srand(20);
                p[2] = srand(20);
                rest = cur_coef[3] <<< FRAC_BITS;
                for (int k = 1; k < n; k++)
                    rest += cur_coef[k] * p[k];
                p[0] = -(rest >>> FRAC_BITS);
                if ($urandom_range(4) == 0)
                    p[0] += $urandom_range(0, 2) - 1;
            end
            else
            begin
                p[cur_mode - MODE_POLY_X] = $urandom_range(1) ? root_a : root_b;
                if ($urandom_range(3) == 0)
                    p[cur_mode - MODE_POLY_X] = srand(20);
            end
        end
        send_node($urandom(), dims, p[0], p[1], p[2]);
    endtask

    initial
    begin
        longint c[NUM_COEF];
        rst_n      <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_idx    <= '0;
        cfg_wdata  <= '0;
        in_valid   <= 1'b0;
        node_tag   <= '0;
        dim_count  <= '0;
        coord_x    <= '0;
        coord_y    <= '0;
        coord_z    <= '0;
        draining   = 1'b0;
        nodes_sent = 0;
        tx_idle    = 0;
        rx_idle    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: segment on one axis from 0 to 0
        send_node(32'h0000_0001, 1, 0, 5, 5);
        send_node(32'hFFFF_FFFF, 1, 1, 0, 0);
        send_node(32'h8000_0000, 0, 0, 0, 0);

        // segment (1,2,3) to (17,34,51)
        c = '{1 <<< 16, 2 <<< 16, 3 <<< 16, 17 <<< 16, 34 <<< 16, 51 <<< 16};
        settle();
        load_primitive(MODE_SEG, 3, c);
        send_node(32'h10, 3, 1 <<< 16, 2 <<< 16, 3 <<< 16);
        send_node(32'h11, 3, 17 <<< 16, 34 <<< 16, 51 <<< 16);
        send_node(32'h12, 3, 9 <<< 16, 18 <<< 16, 27 <<< 16);
        send_node(32'h13, 3, 9 <<< 16, (18 <<< 16) + 1, 27 <<< 16);
        send_node(32'h14, 3, 9 <<< 16, (18 <<< 16) + 2, 27 <<< 16);
        send_node(32'h15, 3, 18 <<< 16, 36 <<< 16, 54 <<< 16);
        send_node(32'h16, 2, 9 <<< 16, 18 <<< 16, 0);
        send_node(32'h17, 3, 32'h7FFF_FFFF, -32'sh8000_0000, 32'h7FFF_FFFF);

        // plane x + 2y - 4 = 0 in three dimensions
        c = '{1 <<< 16, 2 <<< 16, 0, -(4 <<< 16), 0, 0};
        settle();
        load_primitive(MODE_PLANE, 3, c);
        send_node(32'h20, 3, 4 <<< 16, 0, 12345);
        send_node(32'h21, 3, 2 <<< 16, 1 <<< 16, 0);
        send_node(32'h22, 3, (2 <<< 16) + 1, 1 <<< 16, 0);
        send_node(32'h23, 3, (2 <<< 16) + 2, 1 <<< 16, 0);
        send_node(32'h24, 0, 4 <<< 16, 0, 0);

        // x^2 - 5x + 6 on axis x, roots 2 and 3
        c = '{1 <<< 16, -(5 <<< 16), 6 <<< 16, 0, 0, 0};
        settle();
        load_primitive(MODE_POLY_X, 3, c);
        send_node(32'h30, 1, 2 <<< 16, 0, 0);
        send_node(32'h31, 1, 3 <<< 16, 0, 0);
        send_node(32'h32, 1, 4 <<< 16, 0, 0);
        send_node(32'h33, 0, 2 <<< 16, 0, 0);
        settle();
        c = '{-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, 0, 0, 0};
        load_primitive(MODE_POLY_Z, 3, c);
        send_node(32'h34, 3, 0, 0, 32'h7FFF_FFFF);
        send_node(32'h35, 2, 0, 0, 0);
        settle();
        load_primitive(3'd5, 3, c);
        send_node(32'h36, 3, 0, 0, 0);
        settle();
        load_primitive(3'd6, 7, c);
        send_node(32'h37, 3, 0, 0, 0);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0: pick_segment(1'b0, 3);
                1: pick_segment(1'b1, 7);
                2: pick_segment(1'b0, 2);
                3: pick_plane(3, 1'b0);
                4: pick_plane(1, 1'b1);
                5: pick_roots(MODE_POLY_X, 3);
                6: pick_roots(MODE_POLY_Y, 0);
                7: pick_roots(MODE_POLY_Z, 7);
                default:
                begin
                    for (int i = 0; i < NUM_COEF; i++)
                        c[i] = srand(31);
                    load_primitive(3'd7, $urandom_range(7), c);
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                random_node();
        end

        settle();
        if (error_count == 0 && tags_pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
